### sv/go_to_goal_pid_steering_defines.svh
// Assertion macros shared by the go-to-goal steering RTL.
`ifndef GO_TO_GOAL_PID_STEERING_DEFINES_SVH
`define GO_TO_GOAL_PID_STEERING_DEFINES_SVH

`ifndef ASSERT_OFF
`define GTG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gtg assertion failed");
`define GTG_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("gtg forbidden condition seen");
`else
`define GTG_ASSERT(lbl, prop)
`define GTG_NEVER(lbl, expr)
`endif

`endif

### sv/gtg_pkg.sv
// Shared constants, types and the arctangent table of the go-to-goal steering block.
`timescale 1ns / 1ps
package gtg_pkg;

  localparam int CORDIC_STEPS  = 16;
  localparam int POS_FRAC_BITS = 16;
  localparam int GAIN_FRAC     = 16;
  localparam int GUARD_BITS    = 8;

  localparam int COORD_W  = 32;
  localparam int OFFSET_W = COORD_W + 1;
  localparam int HEAD_W   = 16;
  localparam int GAIN_W   = 24;
  localparam int RADIUS_W = 31;
  localparam int DIST_W   = 32;
  localparam int DSUM_W   = 40;
  localparam int HERR_W   = 17;
  localparam int HSUM_W   = 32;

  localparam int CORDIC_W  = OFFSET_W + GUARD_BITS + 3;
  localparam int ANGLE_W   = 34;
  localparam int ITER_W    = $clog2(CORDIC_STEPS);
  localparam int TAB_IDX_W = 5;
  localparam int MAG_W     = CORDIC_W - GUARD_BITS;

  localparam int MULT_A_W    = 28;
  localparam int MULT_B_W    = 48;
  localparam int MAC_CHUNK_W = 16;
  localparam int PROD_W      = 46;
  localparam int ACC_W       = 66;

  localparam logic [MULT_A_W-1:0] INV_K_Q28   = 28'd163008219;
  localparam logic [30:0]         HALF_PI_Q30 = 31'd1686629713;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_P  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_D  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_I  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_P  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_D  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_I  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd6;

  localparam logic [GAIN_W-1:0]   RST_LIN_P  = 24'd65536;
  localparam logic [GAIN_W-1:0]   RST_LIN_D  = 24'd655;
  localparam logic [GAIN_W-1:0]   RST_LIN_I  = 24'd0;
  localparam logic [GAIN_W-1:0]   RST_ANG_P  = 24'd262144;
  localparam logic [GAIN_W-1:0]   RST_ANG_D  = 24'd6554;
  localparam logic [GAIN_W-1:0]   RST_ANG_I  = 24'd0;
  localparam logic [RADIUS_W-1:0] RST_RADIUS = 31'd6554;

  typedef struct packed {
    logic                start;
    logic [MULT_A_W-1:0] mult_a;
    logic [MULT_B_W-1:0] mult_b;
    logic [ACC_W-1:0]    acc_init;
  } mac_req_t;

  function automatic logic [29:0] atan_q30(input logic [TAB_IDX_W-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'h3243F6A8;
      5'd1:  v = 30'h1DAC6705;
      5'd2:  v = 30'h0FADBAFC;
      5'd3:  v = 30'h07F56EA6;
      5'd4:  v = 30'h03FEAB76;
      5'd5:  v = 30'h01FFD55B;
      5'd6:  v = 30'h00FFFAAA;
      5'd7:  v = 30'h007FFF55;
      5'd8:  v = 30'h003FFFEA;
      5'd9:  v = 30'h001FFFFD;
      5'd10: v = 30'h000FFFFF;
      5'd11: v = 30'h0007FFFF;
      5'd12: v = 30'h0003FFFF;
      5'd13: v = 30'h0001FFFF;
      5'd14: v = 30'h0000FFFF;
      5'd15: v = 30'h00007FFF;
      5'd16: v = 30'h00003FFF;
      5'd17: v = 30'h00001FFF;
      5'd18: v = 30'h00000FFF;
      5'd19: v = 30'h000007FF;
      5'd20: v = 30'h000003FF;
      5'd21: v = 30'h000001FF;
      5'd22: v = 30'h000000FF;
      5'd23: v = 30'h0000007F;
      5'd24: v = 30'h0000003F;
      5'd25: v = 30'h0000001F;
      5'd26: v = 30'h0000000F;
      5'd27: v = 30'h00000007;
      5'd28: v = 30'h00000003;
      5'd29: v = 30'h00000001;
      default: v = 30'h00000000;
    endcase
    return v;
  endfunction

endpackage

### sv/gtg_cordic.sv
// Iterative CORDIC vectoring unit: one micro-rotation per cycle.
`timescale 1ns / 1ps
`include "go_to_goal_pid_steering_defines.svh"
module gtg_cordic
  import gtg_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [OFFSET_W-1:0]        dx_i,
  input  logic [OFFSET_W-1:0]        dy_i,
  output logic                       done_o,
  output logic signed [CORDIC_W-1:0] x_o,
  output logic signed [ANGLE_W-1:0]  z_o
);

  localparam logic signed [ANGLE_W-1:0] HalfPi = ANGLE_W'(HALF_PI_Q30);

  logic                       running_q, running_d;
  logic                       pre_q, pre_d;
  logic                       done_q, done_d;
  logic [ITER_W-1:0]          iter_q, iter_d;
  logic signed [CORDIC_W-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [ANGLE_W-1:0]  z_q, z_d, atan_v;

  assign xs     = x_q >>> iter_q;
  assign ys     = y_q >>> iter_q;
  assign atan_v = {4'b0, atan_q30(TAB_IDX_W'(iter_q))};

  always_comb begin
    running_d = running_q;
    pre_d     = pre_q;
    done_d    = 1'b0;
    iter_d    = iter_q;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    if (start_i) begin
      running_d = 1'b1;
      pre_d     = 1'b1;
      iter_d    = '0;
      x_d       = {{3{dx_i[OFFSET_W-1]}}, dx_i, {GUARD_BITS{1'b0}}};
      y_d       = {{3{dy_i[OFFSET_W-1]}}, dy_i, {GUARD_BITS{1'b0}}};
      z_d       = '0;
    end else if (running_q && pre_q) begin
      pre_d = 1'b0;
      if (x_q[CORDIC_W-1]) begin
        if (!y_q[CORDIC_W-1]) begin
          x_d = y_q;
          y_d = -x_q;
          z_d = HalfPi;
        end else begin
          x_d = -y_q;
          y_d = x_q;
          z_d = -HalfPi;
        end
      end
    end else if (running_q) begin
      if (!y_q[CORDIC_W-1]) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_v;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_v;
      end
      iter_d = iter_q + ITER_W'(1);
      if (iter_q == ITER_W'(CORDIC_STEPS - 1)) begin
        running_d = 1'b0;
        done_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      pre_q     <= 1'b0;
      done_q    <= 1'b0;
      iter_q    <= '0;
    end else begin
      running_q <= running_d;
      pre_q     <= pre_d;
      done_q    <= done_d;
      iter_q    <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign z_o    = z_q;

  `GTG_ASSERT(a_cordic_start_idle, start_i |-> !running_q)
  `GTG_NEVER(a_cordic_done_running, done_q && running_q)

endmodule

### sv/gtg_mac.sv
// Shared multiply-accumulate unit: one 16-bit slice of the multiplier word per cycle.
`timescale 1ns / 1ps
`include "go_to_goal_pid_steering_defines.svh"
module gtg_mac
  import gtg_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_req_t                req_i,
  output logic                    done_o,
  output logic signed [ACC_W-1:0] acc_o
);

  logic                     running_q, running_d;
  logic                     done_q, done_d;
  logic [1:0]               step_q, step_d;
  logic [MULT_A_W-1:0]      a_q, a_d;
  logic [MULT_B_W-1:0]      b_q, b_d;
  logic signed [PROD_W-1:0] prod_q, prod_d, a_ext, c_ext;
  logic signed [ACC_W-1:0]  acc_q, acc_d, pp_ext;
  logic [MAC_CHUNK_W:0]     chunk;

  always_comb begin
    case (step_q)
      2'd0:    chunk = {1'b0, b_q[MAC_CHUNK_W-1:0]};
      2'd1:    chunk = {1'b0, b_q[2*MAC_CHUNK_W-1:MAC_CHUNK_W]};
      default: chunk = {b_q[MULT_B_W-1], b_q[MULT_B_W-1:2*MAC_CHUNK_W]};
    endcase
  end

  assign a_ext  = {{(PROD_W - MULT_A_W){1'b0}}, a_q};
  assign c_ext  = {{(PROD_W - MAC_CHUNK_W - 1){chunk[MAC_CHUNK_W]}}, chunk};
  assign pp_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    running_d = running_q;
    done_d    = 1'b0;
    step_d    = step_q;
    a_d       = a_q;
    b_d       = b_q;
    prod_d    = prod_q;
    acc_d     = acc_q;
    if (req_i.start) begin
      running_d = 1'b1;
      step_d    = 2'd0;
      a_d       = req_i.mult_a;
      b_d       = req_i.mult_b;
      acc_d     = req_i.acc_init;
    end else if (running_q) begin
      prod_d = a_ext * c_ext;
      step_d = step_q + 2'd1;
      case (step_q)
        2'd1:    acc_d = acc_q + pp_ext;
        2'd2:    acc_d = acc_q + (pp_ext <<< MAC_CHUNK_W);
        2'd3:    acc_d = acc_q + (pp_ext <<< (2 * MAC_CHUNK_W));
        default: acc_d = acc_q;
      endcase
      if (step_q == 2'd3) begin
        running_d = 1'b0;
        done_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      step_q    <= 2'd0;
    end else begin
      running_q <= running_d;
      done_q    <= done_d;
      step_q    <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

  `GTG_ASSERT(a_mac_start_idle, req_i.start |-> !running_q)
  `GTG_NEVER(a_mac_done_running, done_q && running_q)

endmodule

### sv/go_to_goal_pid_steering.sv
// Top level of the go-to-goal PID steering block: sequencer, PID state and stream ports.
// One input word (goal and pose) gives one output word (linear speed, turn rate,
// not-arrived flag). The CORDIC vectoring loop takes one micro-rotation per cycle,
// then seven products (magnitude scaling and six PID terms) pass through one
// shared 29x17 multiplier in turn. s_axis_tready_o is high only between items; a
// finished word waits in the output register while the next item is taken. Gains
// and the arrival radius are to be written through the cfg port only while the
// block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`include "go_to_goal_pid_steering_defines.svh"
module go_to_goal_pid_steering
  import gtg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // target_x, target_y, pose_x, pose_y, pose_heading
  input  logic [143:0]         s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // linear_speed, turn_rate
  output logic [63:0]          m_axis_tdata_o,
  // not_arrived
  output logic                 m_axis_tuser_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [RADIUS_W-1:0]  cfg_data_i
);

  localparam int TERM_W    = 52;
  localparam int MAG_SHIFT = 28;
  localparam int ANG_SHIFT = 29 - POS_FRAC_BITS;
  localparam logic [ACC_W-1:0] MagHalf = ACC_W'(1) << (MAG_SHIFT - 1);
  localparam logic [ACC_W-1:0] LinHalf = ACC_W'(1) << (GAIN_FRAC - 1);
  localparam logic [ACC_W-1:0] AngHalf = ACC_W'(1) << (ANG_SHIFT - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CORDIC = 3'd1;
  localparam logic [2:0] S_MAG    = 3'd2;
  localparam logic [2:0] S_UPD    = 3'd3;
  localparam logic [2:0] S_LAUNCH = 3'd4;
  localparam logic [2:0] S_WAIT   = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  localparam logic [2:0] OP_MAG = 3'd0;
  localparam logic [2:0] OP_LP  = 3'd1;
  localparam logic [2:0] OP_LD  = 3'd2;
  localparam logic [2:0] OP_LI  = 3'd3;
  localparam logic [2:0] OP_AP  = 3'd4;
  localparam logic [2:0] OP_AD  = 3'd5;
  localparam logic [2:0] OP_AI  = 3'd6;

  function automatic logic [31:0] sat32(input logic signed [TERM_W-1:0] v);
    logic [31:0] r;
    if (v[TERM_W-1:31] == {(TERM_W - 31){v[TERM_W-1]}}) begin
      r = v[31:0];
    end else if (v[TERM_W-1]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  logic [2:0]          state_q, state_d;
  logic [2:0]          op_q, op_d, op_sel;
  logic                out_valid_q, out_valid_d;

  logic [GAIN_W-1:0]   lin_p_q, lin_p_d, lin_d_q, lin_d_d, lin_i_q, lin_i_d;
  logic [GAIN_W-1:0]   ang_p_q, ang_p_d, ang_d_q, ang_d_d, ang_i_q, ang_i_d;
  logic [RADIUS_W-1:0] radius_q, radius_d;

  logic [DIST_W-1:0]        last_dist_q, last_dist_d;
  logic [DSUM_W-1:0]        dsum_q, dsum_d;
  logic signed [HERR_W-1:0] last_herr_q, last_herr_d;
  logic signed [HSUM_W-1:0] hsum_q, hsum_d;

  logic signed [HEAD_W-1:0]   heading_q, heading_d;
  logic [DIST_W-1:0]          dist_q, dist_d;
  logic signed [HERR_W-1:0]   herr_q, herr_d;
  logic signed [DIST_W:0]     ddist_q, ddist_d;
  logic signed [HERR_W:0]     dherr_q, dherr_d;
  logic signed [TERM_W-1:0]   lin_q, lin_d, ang_q, ang_d;
  logic [31:0]                lin_out_q, lin_out_d, ang_out_q, ang_out_d;
  logic                       arr_q, arr_d;

  logic                       in_accept;
  logic [OFFSET_W-1:0]        dx, dy;
  logic                       cordic_done;
  logic signed [CORDIC_W-1:0] cordic_x;
  logic signed [ANGLE_W-1:0]  cordic_z, z_rnd;
  logic signed [HERR_W-1:0]   bearing;
  logic signed [HERR_W:0]     herr_full;
  logic [MAG_W-1:0]           mag_m;
  logic [DSUM_W:0]            dsum_full;
  logic signed [HSUM_W:0]     hsum_full;
  logic                       mac_done;
  logic signed [ACC_W-1:0]    mac_acc, acc_lin_sh, acc_ang_sh;
  logic signed [TERM_W-1:0]   term;
  mac_req_t                   mac_req;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign dx = {s_axis_tdata_i[31], s_axis_tdata_i[31:0]}
            - {s_axis_tdata_i[95], s_axis_tdata_i[95:64]};
  assign dy = {s_axis_tdata_i[63], s_axis_tdata_i[63:32]}
            - {s_axis_tdata_i[127], s_axis_tdata_i[127:96]};

  gtg_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .dx_i    (dx),
    .dy_i    (dy),
    .done_o  (cordic_done),
    .x_o     (cordic_x),
    .z_o     (cordic_z)
  );

  gtg_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  assign mag_m     = cordic_x[CORDIC_W-1] ? '0 : cordic_x[CORDIC_W-1:GUARD_BITS];
  assign z_rnd     = cordic_z + (ANGLE_W'(1) <<< 16);
  assign bearing   = z_rnd[ANGLE_W-1:17];
  assign herr_full = {bearing[HERR_W-1], bearing}
                   - {{(HERR_W + 1 - HEAD_W){heading_q[HEAD_W-1]}}, heading_q};

  assign dsum_full = {1'b0, dsum_q} + (DSUM_W + 1)'(dist_q);
  assign hsum_full = {hsum_q[HSUM_W-1], hsum_q}
                   + {{(HSUM_W + 1 - HERR_W){herr_q[HERR_W-1]}}, herr_q};

  assign acc_lin_sh = mac_acc >>> GAIN_FRAC;
  assign acc_ang_sh = mac_acc >>> ANG_SHIFT;
  assign term = (op_q <= OP_LI) ? acc_lin_sh[TERM_W-1:0] : acc_ang_sh[TERM_W-1:0];

  always_comb begin
    if (state_q == S_CORDIC) begin
      op_sel = OP_MAG;
    end else if (state_q == S_LAUNCH) begin
      op_sel = op_q;
    end else begin
      op_sel = op_q + 3'd1;
    end
  end

  always_comb begin
    mac_req.start = (state_q == S_CORDIC && cordic_done) || (state_q == S_LAUNCH)
                  || (state_q == S_WAIT && mac_done && op_q != OP_AI);
    case (op_sel)
      OP_MAG: begin
        mac_req.mult_a   = INV_K_Q28;
        mac_req.mult_b   = MULT_B_W'(mag_m);
        mac_req.acc_init = MagHalf;
      end
      OP_LP: begin
        mac_req.mult_a   = MULT_A_W'(lin_p_q);
        mac_req.mult_b   = MULT_B_W'(dist_q);
        mac_req.acc_init = LinHalf;
      end
      OP_LD: begin
        mac_req.mult_a   = MULT_A_W'(lin_d_q);
        mac_req.mult_b   = {{(MULT_B_W - DIST_W - 1){ddist_q[DIST_W]}}, ddist_q};
        mac_req.acc_init = LinHalf;
      end
      OP_LI: begin
        mac_req.mult_a   = MULT_A_W'(lin_i_q);
        mac_req.mult_b   = MULT_B_W'(dsum_q);
        mac_req.acc_init = LinHalf;
      end
      OP_AP: begin
        mac_req.mult_a   = MULT_A_W'(ang_p_q);
        mac_req.mult_b   = {{(MULT_B_W - HERR_W){herr_q[HERR_W-1]}}, herr_q};
        mac_req.acc_init = AngHalf;
      end
      OP_AD: begin
        mac_req.mult_a   = MULT_A_W'(ang_d_q);
        mac_req.mult_b   = {{(MULT_B_W - HERR_W - 1){dherr_q[HERR_W]}}, dherr_q};
        mac_req.acc_init = AngHalf;
      end
      default: begin
        mac_req.mult_a   = MULT_A_W'(ang_i_q);
        mac_req.mult_b   = {{(MULT_B_W - HSUM_W){hsum_q[HSUM_W-1]}}, hsum_q};
        mac_req.acc_init = AngHalf;
      end
    endcase
  end

  always_comb begin
    lin_p_d  = lin_p_q;
    lin_d_d  = lin_d_q;
    lin_i_d  = lin_i_q;
    ang_p_d  = ang_p_q;
    ang_d_d  = ang_d_q;
    ang_i_d  = ang_i_q;
    radius_d = radius_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LIN_P:  lin_p_d  = cfg_data_i[GAIN_W-1:0];
        CFG_LIN_D:  lin_d_d  = cfg_data_i[GAIN_W-1:0];
        CFG_LIN_I:  lin_i_d  = cfg_data_i[GAIN_W-1:0];
        CFG_ANG_P:  ang_p_d  = cfg_data_i[GAIN_W-1:0];
        CFG_ANG_D:  ang_d_d  = cfg_data_i[GAIN_W-1:0];
        CFG_ANG_I:  ang_i_d  = cfg_data_i[GAIN_W-1:0];
        CFG_RADIUS: radius_d = cfg_data_i;
        default:    radius_d = radius_q;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    out_valid_d = out_valid_q;
    last_dist_d = last_dist_q;
    dsum_d      = dsum_q;
    last_herr_d = last_herr_q;
    hsum_d      = hsum_q;
    heading_d   = heading_q;
    dist_d      = dist_q;
    herr_d      = herr_q;
    ddist_d     = ddist_q;
    dherr_d     = dherr_q;
    lin_d       = lin_q;
    ang_d       = ang_q;
    lin_out_d   = lin_out_q;
    ang_out_d   = ang_out_q;
    arr_d       = arr_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          heading_d = s_axis_tdata_i[143:128];
          state_d   = S_CORDIC;
        end
      end
      S_CORDIC: begin
        if (cordic_done) begin
          state_d = S_MAG;
        end
      end
      S_MAG: begin
        if (mac_done) begin
          if (|mac_acc[ACC_W-1:MAG_SHIFT+DIST_W]) begin
            dist_d = '1;
          end else begin
            dist_d = mac_acc[MAG_SHIFT+DIST_W-1:MAG_SHIFT];
          end
          herr_d  = herr_full[HERR_W-1:0];
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        ddist_d     = $signed({1'b0, dist_q}) - $signed({1'b0, last_dist_q});
        last_dist_d = dist_q;
        dsum_d      = dsum_full[DSUM_W] ? '1 : dsum_full[DSUM_W-1:0];
        dherr_d     = {herr_q[HERR_W-1], herr_q} - {last_herr_q[HERR_W-1], last_herr_q};
        last_herr_d = herr_q;
        if (hsum_full[HSUM_W] != hsum_full[HSUM_W-1]) begin
          hsum_d = hsum_full[HSUM_W] ? {1'b1, {(HSUM_W - 1){1'b0}}}
                                     : {1'b0, {(HSUM_W - 1){1'b1}}};
        end else begin
          hsum_d = hsum_full[HSUM_W-1:0];
        end
        lin_d   = '0;
        ang_d   = '0;
        op_d    = OP_LP;
        state_d = S_LAUNCH;
      end
      S_LAUNCH: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (mac_done) begin
          if (op_q <= OP_LI) begin
            lin_d = lin_q + term;
          end else begin
            ang_d = ang_q + term;
          end
          if (op_q == OP_AI) begin
            state_d = S_FIN;
          end else begin
            op_d = op_q + 3'd1;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready_i) begin
          lin_out_d   = sat32(lin_q);
          ang_out_d   = sat32(ang_q);
          arr_d       = (dist_q >= {1'b0, radius_q});
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      lin_p_q     <= RST_LIN_P;
      lin_d_q     <= RST_LIN_D;
      lin_i_q     <= RST_LIN_I;
      ang_p_q     <= RST_ANG_P;
      ang_d_q     <= RST_ANG_D;
      ang_i_q     <= RST_ANG_I;
      radius_q    <= RST_RADIUS;
      last_dist_q <= '0;
      dsum_q      <= '0;
      last_herr_q <= '0;
      hsum_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      lin_p_q     <= lin_p_d;
      lin_d_q     <= lin_d_d;
      lin_i_q     <= lin_i_d;
      ang_p_q     <= ang_p_d;
      ang_d_q     <= ang_d_d;
      ang_i_q     <= ang_i_d;
      radius_q    <= radius_d;
      last_dist_q <= last_dist_d;
      dsum_q      <= dsum_d;
      last_herr_q <= last_herr_d;
      hsum_q      <= hsum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    heading_q <= heading_d;
    dist_q    <= dist_d;
    herr_q    <= herr_d;
    ddist_q   <= ddist_d;
    dherr_q   <= dherr_d;
    lin_q     <= lin_d;
    ang_q     <= ang_d;
    lin_out_q <= lin_out_d;
    ang_out_q <= ang_out_d;
    arr_q     <= arr_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {ang_out_q, lin_out_q};
  assign m_axis_tuser_o  = arr_q;

  `GTG_ASSERT(a_busy_after_accept, in_accept |=> !s_axis_tready_o)
  `GTG_ASSERT(a_cordic_done_state, cordic_done |-> state_q == S_CORDIC)
  `GTG_ASSERT(a_mac_done_state, mac_done |-> (state_q == S_MAG || state_q == S_WAIT))

endmodule
